/* design/lsb_first_bit_fifo_macros.svh */
// Assertion macros for the bit queue top level.
`ifndef LSB_FIRST_BIT_FIFO_MACROS_SVH
`define LSB_FIRST_BIT_FIFO_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define LBF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lsb_first_bit_fifo: assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define LBF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lsb_first_bit_fifo: assertion failed");

`endif

/* design/lbf_pkg.sv */
// Shared types, codes and helpers for the LSB-first bit queue.
package lbf_pkg;

  // Default store size in bytes.
  localparam int STORE_BYTES_DEF = 256;

  // Command codes.
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic       command;
    logic [3:0] bit_count;
    logic [7:0] data_in;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BYTE0,
    S_BYTE1,
    S_RESP
  } lbf_state_t;

  // Control of the shared alignment unit.
  typedef struct packed {
    logic       get;     // 1: extract (shift right), 0: insert (shift left)
    logic [2:0] amount;  // bit offset inside the byte
    logic [3:0] count;   // bits moved, 0 to 8
  } lbf_shift_ctl_t;

  // Mask of the low n bits, n in 0 to 8.
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

/* design/lbf_shift.sv */
// Shared alignment unit: places bits into or pulls bits out of a byte pair.
module lbf_shift (
  input  lbf_pkg::lbf_shift_ctl_t ctl,
  input  logic [15:0]             value,
  output logic [15:0]             result
);
  import lbf_pkg::*;

  logic [15:0] right_sh;

  // Extract: byte pair shifted down, keep count bits.
  // Insert: masked data byte shifted up to the bit offset.
  always_comb begin
    right_sh = value >> ctl.amount;
    if (ctl.get) begin
      result = {8'h00, right_sh[7:0] & low_mask(ctl.count)};
    end else begin
      result = {8'h00, value[7:0] & low_mask(ctl.count)} << ctl.amount;
    end
  end

endmodule

/* design/lsb_first_bit_fifo.sv */
// Bit-granular queue, LSB first into a byte store: top level.
//
// Usage:
//   in_valid / in_stall / in_data carry one command per transaction: put
//   appends the low bit_count bits of data_in at the write bit position,
//   get extracts bit_count bits from the read bit position. bit_count
//   above eight counts as eight; zero moves nothing.
//   out_valid / out_stall / out_data return one transaction per command:
//   data_out (get data, zero-extended) and status (ok, overflow on put,
//   underflow on get). A failed command changes nothing.
// Sequencing:
//   One sequencer shares a byte-pair aligner and the store: check and
//   first-byte read, first byte, second byte on a byte-boundary straddle,
//   result register. A failed or zero-count command goes from the check
//   straight to the result register. A put merges its first byte with
//   the stored byte read in the check step.
//   in_stall is high while a command is in flight.
// Reset and back-pressure:
//   Reset clears the positions and the result valid, not the store.
//   Under out_stall the next command runs, then waits in its last step.
module lsb_first_bit_fifo #(
  parameter int STORE_BYTES = lbf_pkg::STORE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lbf_pkg::out_item_t out_data
);
  import lbf_pkg::*;

  localparam int POS_W = $clog2(STORE_BYTES * 8 + 1);
  localparam int IDX_W = $clog2(STORE_BYTES);
  localparam logic [POS_W:0] CAP_BITS = (POS_W + 1)'(STORE_BYTES * 8);

  // Control and payload registers.
  lbf_state_t       state_r, state_nxt;
  logic [POS_W-1:0] wr_pos_r, rd_pos_r;
  logic             cmd_r;
  logic [3:0]       cnt_r;
  logic [7:0]       din_r;
  logic [7:0]       b0_r;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r;
  logic             out_valid_r;

  // Store.
  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       mem_rdata_r;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]       mem_wdata;

  // Step controls.
  logic             b0_ld, res_ld, wr_adv, rd_adv, out_ld;

  // Datapath terms.
  logic [POS_W-1:0] pos_sel;
  logic [2:0]       bit_sh;
  logic [IDX_W-1:0] idx0, idx1;
  logic             straddle;
  logic [POS_W:0]   end_pos;
  logic             fail;
  logic [3:0]       cnt_sat;
  lbf_shift_ctl_t   sh_ctl;
  logic [15:0]      sh_value, sh_result;

  // Position of the current command and its byte split.
  always_comb begin
    pos_sel  = (cmd_r == CMD_GET) ? rd_pos_r : wr_pos_r;
    bit_sh   = pos_sel[2:0];
    idx0     = pos_sel[IDX_W+2:3];
    idx1     = idx0 + IDX_W'(1);
    straddle = ({2'b00, bit_sh} + {1'b0, cnt_r}) > 5'd8;
    end_pos  = {1'b0, pos_sel} + (POS_W + 1)'(cnt_r);
    if (cmd_r == CMD_GET) begin
      fail = end_pos > {1'b0, wr_pos_r};
    end else begin
      fail = end_pos > CAP_BITS;
    end
    cnt_sat = (in_data.bit_count > 4'd8) ? 4'd8 : in_data.bit_count;
  end

  // Shared aligner operands.
  always_comb begin
    sh_ctl.get    = (cmd_r == CMD_GET);
    sh_ctl.amount = bit_sh;
    sh_ctl.count  = cnt_r;
    if (cmd_r == CMD_PUT) begin
      sh_value = {8'h00, din_r};
    end else if (state_r == S_BYTE1) begin
      sh_value = {mem_rdata_r, b0_r};
    end else begin
      sh_value = {8'h00, mem_rdata_r};
    end
  end

  lbf_shift u_shift (
    .ctl    (sh_ctl),
    .value  (sh_value),
    .result (sh_result)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (cnt_r == 4'd0 || fail) state_nxt = S_RESP;
        else                       state_nxt = S_BYTE0;
      end
      S_BYTE0: state_nxt = straddle ? S_BYTE1 : S_RESP;
      S_BYTE1: state_nxt = S_RESP;
      S_RESP:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: step outputs.
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mem_re    = 1'b0;
    mem_raddr = idx0;
    mem_we    = 1'b0;
    mem_waddr = idx0;
    mem_wdata = sh_result[7:0];
    b0_ld     = 1'b0;
    res_ld    = 1'b0;
    res_nxt   = '{data_out: 8'h00, status: ST_OK};
    wr_adv    = 1'b0;
    rd_adv    = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      S_IDLE: ;
      S_CHECK: begin
        if (cnt_r == 4'd0) begin
          res_ld = 1'b1;
        end else if (fail) begin
          res_ld         = 1'b1;
          res_nxt.status = (cmd_r == CMD_GET) ? ST_UNDERFLOW : ST_OVERFLOW;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_BYTE0: begin
        res_ld = 1'b1;
        if (cmd_r == CMD_PUT) begin
          // keep stored bits below the write position
          mem_we    = 1'b1;
          mem_wdata = (mem_rdata_r & low_mask({1'b0, bit_sh})) | sh_result[7:0];
          wr_adv    = !straddle;
        end else begin
          b0_ld = 1'b1;
          if (straddle) begin
            mem_re    = 1'b1;
            mem_raddr = idx1;
          end else begin
            res_nxt.data_out = sh_result[7:0];
            rd_adv           = 1'b1;
          end
        end
      end
      S_BYTE1: begin
        res_ld = 1'b1;
        if (cmd_r == CMD_PUT) begin
          mem_we    = 1'b1;
          mem_waddr = idx1;
          mem_wdata = sh_result[15:8];
          wr_adv    = 1'b1;
        end else begin
          res_nxt.data_out = sh_result[7:0];
          rd_adv           = 1'b1;
        end
      end
      S_RESP: out_ld = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_adv) wr_pos_r <= end_pos[POS_W-1:0];
      if (rd_adv) rd_pos_r <= end_pos[POS_W-1:0];
      if (out_ld)          out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_data.command;
      cnt_r <= cnt_sat;
      din_r <= in_data.data_in;
    end
    if (b0_ld)  b0_r  <= mem_rdata_r;
    if (res_ld) res_r <= res_nxt;
    if (out_ld) out_r <= res_r;
  end

  // Byte store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks.
  `include "lsb_first_bit_fifo_macros.svh"

  `LBF_ASSERT_NOW(a_read_behind_write, 1'b1, rd_pos_r <= wr_pos_r)
  `LBF_ASSERT_NOW(a_write_in_capacity, 1'b1, {1'b0, wr_pos_r} <= CAP_BITS)
  `LBF_ASSERT_NEXT(a_pos_hold_idle, state_r == S_IDLE, $stable(wr_pos_r) && $stable(rd_pos_r))

endmodule

/* sim/tb.sv */
// Testbench for the LSB-first bit queue: directed, random and fill/drain runs.
`timescale 1ns / 1ps

module tb;
  import lbf_pkg::*;

  localparam int CAP_BITS    = STORE_BYTES_DEF * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 24;
  localparam int TAIL_CYCLES = 12;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Shadow copy of the queue state
  logic [7:0] shadow_bytes [STORE_BYTES_DEF];
  int         rd_bits;
  int         wr_bits;

  out_item_t  expected_results [$];
  out_item_t  oldest_result;
  int         err_cnt;
  int         cycle_cnt;
  bit         in_idle_en;
  bit         out_idle_en;

  lsb_first_bit_fifo #(
    .STORE_BYTES(STORE_BYTES_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: data_out %0h status %0d",
               out_data.data_out, out_data.status);
        err_cnt++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data.data_out !== oldest_result.data_out) begin
          $error("data_out expected %0h actual %0h",
                 oldest_result.data_out, out_data.data_out);
          err_cnt++;
        end
        if (out_data.status !== oldest_result.status) begin
          $error("status expected %0d actual %0d",
                 oldest_result.status, out_data.status);
          err_cnt++;
        end
      end
    end
  end

  // Predict the result of one command and advance the shadow state
  function automatic out_item_t predict_bit_queue(input in_item_t item);
    out_item_t  res;
    int         n;
    int         p;
    res.data_out = 8'd0;
    res.status   = ST_OK;
    n = (item.bit_count > 4'd8) ? 8 : int'(item.bit_count);
    if (n != 0) begin
      if (item.command == CMD_PUT) begin
        if (wr_bits + n > CAP_BITS) begin
          res.status = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < n; i++) begin
            p = wr_bits + i;
            shadow_bytes[p >> 3][p & 7] = item.data_in[i];
          end
          wr_bits += n;
        end
      end else begin
        if (rd_bits + n > wr_bits) begin
          res.status = ST_UNDERFLOW;
        end else begin
          for (int i = 0; i < n; i++) begin
            p = rd_bits + i;
            res.data_out[i] = shadow_bytes[p >> 3][p & 7];
          end
          rd_bits += n;
        end
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_cmd(input logic cmd, input int cnt, input int data);
    in_item_t it;
    it.command   = cmd;
    it.bit_count = 4'(cnt);
    it.data_in   = 8'(data);
    return it;
  endfunction

  // Random command; most gets ask for no more than is stored
  function automatic in_item_t random_cmd();
    in_item_t it;
    int       avail;
    int       pick;
    it.data_in = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)
      it.bit_count = 4'd0;
    else if (pick < 20)
      it.bit_count = 4'($urandom_range(15, 9));
    else
      it.bit_count = 4'($urandom_range(8, 1));
    if ($urandom_range(99) < 28) begin
      it.command = CMD_PUT;
    end else begin
      it.command = CMD_GET;
      avail = wr_bits - rd_bits;
      if (avail > 0 && it.bit_count != 4'd0 && $urandom_range(99) < 85)
        it.bit_count = 4'($urandom_range((avail < 8) ? avail : 8, 1));
    end
    return it;
  endfunction

  // Send one command transaction; entered and left at a falling edge
  task automatic send_cmd(input in_item_t item);
    while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_bit_queue(item));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes of the fields, zero and oversized counts, straddles, underflow
  task automatic test_directed();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    send_cmd(make_cmd(CMD_GET, 1, 8'h00));   // underflow on empty queue
    send_cmd(make_cmd(CMD_GET, 0, 8'hFF));   // zero count get
    send_cmd(make_cmd(CMD_PUT, 0, 8'hFF));   // zero count put
    send_cmd(make_cmd(CMD_PUT, 8, 8'hA5));
    send_cmd(make_cmd(CMD_GET, 8, 8'h00));
    send_cmd(make_cmd(CMD_PUT, 3, 8'hFD));   // only low bits kept
    send_cmd(make_cmd(CMD_PUT, 8, 8'hC3));   // straddles a byte boundary
    send_cmd(make_cmd(CMD_PUT, 15, 8'h5A));  // oversized count saturates
    send_cmd(make_cmd(CMD_PUT, 9, 8'h00));
    send_cmd(make_cmd(CMD_PUT, 8, 8'hFF));
    send_cmd(make_cmd(CMD_GET, 15, 8'hFF));
    send_cmd(make_cmd(CMD_GET, 3, 8'h00));
    send_cmd(make_cmd(CMD_GET, 9, 8'h00));
    send_cmd(make_cmd(CMD_PUT, 1, 8'hFE));
    send_cmd(make_cmd(CMD_PUT, 7, 8'h7F));
    send_cmd(make_cmd(CMD_GET, 5, 8'h00));
    send_cmd(make_cmd(CMD_GET, 8, 8'h00));
    send_cmd(make_cmd(CMD_GET, 12, 8'h00));  // oversized get count saturates
    send_cmd(make_cmd(CMD_GET, 4, 8'h00));
    send_cmd(make_cmd(CMD_GET, 1, 8'h00));
    send_cmd(make_cmd(CMD_GET, 8, 8'h00));
    wait_drain();
  endtask

  // Long stretch without idling on either side
  task automatic test_back_to_back();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    repeat (300) send_cmd(random_cmd());
    wait_drain();
  endtask

  task automatic test_random_mix();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (1350) send_cmd(random_cmd());
    wait_drain();
  endtask

  // Fill to capacity, hit overflow, then empty it and hit underflow
  task automatic test_fill_and_drain();
    int room;
    int cnt;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    while (wr_bits < CAP_BITS) begin
      room = CAP_BITS - wr_bits;
      if (room < 8)
        send_cmd(make_cmd(CMD_PUT, 8, $urandom));  // overflow just short of full
      cnt = $urandom_range(8, 1);
      if (cnt > room)
        cnt = room;
      send_cmd(make_cmd(CMD_PUT, cnt, $urandom));
    end
    send_cmd(make_cmd(CMD_PUT, 1, 8'hFF));
    send_cmd(make_cmd(CMD_PUT, 15, 8'h00));
    send_cmd(make_cmd(CMD_PUT, 0, 8'hAA));
    while (rd_bits < wr_bits) begin
      cnt = $urandom_range(8, 1);
      if (cnt > wr_bits - rd_bits)
        cnt = wr_bits - rd_bits;
      send_cmd(make_cmd(CMD_GET, cnt, $urandom));
    end
    send_cmd(make_cmd(CMD_GET, 1, 8'h00));
    send_cmd(make_cmd(CMD_GET, 9, 8'hFF));
    wait_drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    rd_bits     = 0;
    wr_bits     = 0;
    foreach (shadow_bytes[i]) shadow_bytes[i] = 8'd0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_back_to_back();
    test_random_mix();
    test_fill_and_drain();

    // Let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
